FILE: rtl/core/rrts_pkg.sv
`default_nettype none

package rrts_pkg;

    localparam int MAX_TASKS = 64;
    localparam int SLOT_W    = 6;
    localparam int FILL_W    = 7;
    localparam int ID_W      = 32;
    localparam int RSTATE_W  = 2;

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_YIELD  = 3'd2;
    localparam logic [2:0] OP_SET    = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NONE     = 2'd2;
    localparam logic [1:0] STATUS_BAD_SLOT = 2'd3;

    localparam logic [RSTATE_W-1:0] RS_READY   = 2'd0;
    localparam logic [RSTATE_W-1:0] RS_RUNNING = 2'd1;

    typedef struct packed {
        logic [2:0]          op;
        logic [SLOT_W-1:0]   target_slot;
        logic [ID_W-1:0]     query_id;
        logic [RSTATE_W-1:0] new_state;
    } t_cmd;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] result_slot;
        logic [ID_W-1:0]   result_id;
        logic              switched;
        logic [SLOT_W-1:0] current_slot;
        logic              current_valid;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [RSTATE_W-1:0] run_state;
        logic [SLOT_W-1:0]   link;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        t_entry            wr_data;
    } t_mem_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CREATE_LINK,
        S_CREATE_HEAD,
        S_SET,
        S_YIELD_PREV,
        S_YIELD_WALK,
        S_YIELD_OLD,
        S_FIND
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/rrts_ram.sv
`default_nettype none

module rrts_ram #(
    parameter int WIDTH  = 40,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/core/rrts_ctrl.sv
`default_nettype none

module rrts_ctrl
    import rrts_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire t_cmd    i_cmd,
    input  wire t_entry  i_rd_data,
    output t_mem_req     o_mem_req,
    output logic         busy,
    output logic         o_done,
    output t_result      o_result
);

    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_TASKS);

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic [SLOT_W-1:0]   r_cur, n_cur;
    logic                r_has, n_has;
    logic [ID_W-1:0]     r_idc, n_idc;
    logic [SLOT_W-1:0]   r_ptr, n_ptr;
    logic [FILL_W-1:0]   r_cnt, n_cnt;
    t_entry              r_prev, n_prev;
    logic [1:0]          r_status, n_status;
    logic [SLOT_W-1:0]   r_rslot, n_rslot;
    logic [ID_W-1:0]     r_rid, n_rid;
    logic                r_sw, n_sw;
    logic                r_done, n_done;
    t_mem_req            mem;
    logic [SLOT_W-1:0]   slot_new;

    assign slot_new = r_fill[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_head <= '0;
            r_cur  <= '0;
            r_has  <= 1'b0;
            r_idc  <= ID_W'(1);
            r_done <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_head <= n_head;
            r_cur  <= n_cur;
            r_has  <= n_has;
            r_idc  <= n_idc;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_ptr    <= n_ptr;
        r_cnt    <= n_cnt;
        r_prev   <= n_prev;
        r_status <= n_status;
        r_rslot  <= n_rslot;
        r_rid    <= n_rid;
        r_sw     <= n_sw;
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_fill   = r_fill;
        n_head   = r_head;
        n_cur    = r_cur;
        n_has    = r_has;
        n_idc    = r_idc;
        n_ptr    = r_ptr;
        n_cnt    = r_cnt;
        n_prev   = r_prev;
        n_status = r_status;
        n_rslot  = r_rslot;
        n_rid    = r_rid;
        n_sw     = r_sw;
        n_done   = 1'b0;
        mem      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = i_cmd;
                    n_status = STATUS_NONE;
                    n_rslot  = '0;
                    n_rid    = '0;
                    n_sw     = 1'b0;
                    unique case (i_cmd.op)
                        OP_CREATE: begin
                            if (r_fill >= FILL_MAX) begin
                                n_status = STATUS_FULL;
                                n_done   = 1'b1;
                            end else if (r_fill == '0) begin
                                mem.wr_en             = 1'b1;
                                mem.wr_addr           = slot_new;
                                mem.wr_data.id        = r_idc;
                                mem.wr_data.run_state = i_cmd.new_state;
                                mem.wr_data.link      = slot_new;
                                n_head   = slot_new;
                                n_fill   = r_fill + 1'b1;
                                n_idc    = r_idc + 1'b1;
                                n_status = STATUS_OK;
                                n_rslot  = slot_new;
                                n_rid    = r_idc;
                                n_done   = 1'b1;
                            end else begin
                                mem.rd_en   = 1'b1;
                                mem.rd_addr = r_head;
                                n_state     = S_CREATE_LINK;
                            end
                        end
                        OP_START, OP_SET: begin
                            if ({1'b0, i_cmd.target_slot} >= r_fill) begin
                                n_status = STATUS_BAD_SLOT;
                                n_done   = 1'b1;
                            end else begin
                                mem.rd_en   = 1'b1;
                                mem.rd_addr = i_cmd.target_slot;
                                n_state     = S_SET;
                            end
                        end
                        OP_YIELD: begin
                            if (!r_has) begin
                                n_done = 1'b1;
                            end else begin
                                mem.rd_en   = 1'b1;
                                mem.rd_addr = r_cur;
                                n_state     = S_YIELD_PREV;
                            end
                        end
                        OP_FIND: begin
                            if (r_fill == '0) begin
                                n_done = 1'b1;
                            end else begin
                                mem.rd_en   = 1'b1;
                                mem.rd_addr = r_head;
                                n_ptr       = r_head;
                                n_cnt       = FILL_W'(1);
                                n_state     = S_FIND;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_CREATE_LINK: begin
                mem.wr_en             = 1'b1;
                mem.wr_addr           = slot_new;
                mem.wr_data.id        = r_idc;
                mem.wr_data.run_state = r_cmd.new_state;
                mem.wr_data.link      = i_rd_data.link;
                n_prev   = i_rd_data;
                n_ptr    = slot_new;
                n_fill   = r_fill + 1'b1;
                n_idc    = r_idc + 1'b1;
                n_status = STATUS_OK;
                n_rslot  = slot_new;
                n_rid    = r_idc;
                n_state  = S_CREATE_HEAD;
            end
            S_CREATE_HEAD: begin
                mem.wr_en             = 1'b1;
                mem.wr_addr           = r_head;
                mem.wr_data.id        = r_prev.id;
                mem.wr_data.run_state = r_prev.run_state;
                mem.wr_data.link      = r_ptr;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_SET: begin
                mem.wr_en             = 1'b1;
                mem.wr_addr           = r_cmd.target_slot;
                mem.wr_data.id        = i_rd_data.id;
                mem.wr_data.run_state = (r_cmd.op == OP_START) ? RS_RUNNING
                                                               : r_cmd.new_state;
                mem.wr_data.link      = i_rd_data.link;
                if (r_cmd.op == OP_START) begin
                    n_cur = r_cmd.target_slot;
                    n_has = 1'b1;
                end
                n_status = STATUS_OK;
                n_rslot  = r_cmd.target_slot;
                n_rid    = i_rd_data.id;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_YIELD_PREV: begin
                n_prev = i_rd_data;
                if (i_rd_data.link == r_cur) begin
                    n_rslot = r_cur;
                    n_rid   = i_rd_data.id;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    mem.rd_en   = 1'b1;
                    mem.rd_addr = i_rd_data.link;
                    n_ptr       = i_rd_data.link;
                    n_state     = S_YIELD_WALK;
                end
            end
            S_YIELD_WALK: begin
                // ready or running entries are runnable
                if (i_rd_data.run_state == RS_READY || i_rd_data.run_state == RS_RUNNING) begin
                    mem.wr_en             = 1'b1;
                    mem.wr_addr           = r_ptr;
                    mem.wr_data.id        = i_rd_data.id;
                    mem.wr_data.run_state = RS_RUNNING;
                    mem.wr_data.link      = i_rd_data.link;
                    n_status = STATUS_OK;
                    n_sw     = 1'b1;
                    n_rslot  = r_ptr;
                    n_rid    = i_rd_data.id;
                    n_state  = S_YIELD_OLD;
                end else if (i_rd_data.link == r_cur) begin
                    n_rslot = r_cur;
                    n_rid   = r_prev.id;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    mem.rd_en   = 1'b1;
                    mem.rd_addr = i_rd_data.link;
                    n_ptr       = i_rd_data.link;
                end
            end
            S_YIELD_OLD: begin
                if (r_prev.run_state == RS_RUNNING) begin
                    mem.wr_en             = 1'b1;
                    mem.wr_addr           = r_cur;
                    mem.wr_data.id        = r_prev.id;
                    mem.wr_data.run_state = RS_READY;
                    mem.wr_data.link      = r_prev.link;
                end
                n_cur   = r_ptr;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_FIND: begin
                if (i_rd_data.id == r_cmd.query_id) begin
                    n_status = STATUS_OK;
                    n_rslot  = r_ptr;
                    n_rid    = i_rd_data.id;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_cnt == r_fill) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    mem.rd_en   = 1'b1;
                    mem.rd_addr = i_rd_data.link;
                    n_ptr       = i_rd_data.link;
                    n_cnt       = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_mem_req = mem;
    assign busy      = (r_state != S_IDLE);
    assign o_done    = r_done;

    assign o_result.status        = r_status;
    assign o_result.result_slot   = r_rslot;
    assign o_result.result_id     = r_rid;
    assign o_result.switched      = r_sw;
    assign o_result.current_slot  = r_cur;
    assign o_result.current_valid = r_has;

`ifndef SYNTHESIS
    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem.rd_en && mem.wr_en))
        else $error("memory read and write in the same cycle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("fill count beyond table size");

    a_cur_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_has |-> ({1'b0, r_cur} < r_fill))
        else $error("current slot outside filled table");

    a_item_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted item neither in work nor done");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("done strobe while busy");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/round_robin_task_ring_scheduler_core.sv
// channel   direction  handshake            payload
// command   in         start & !busy        i_cmd    (t_cmd)
// result    out        o_done, one cycle    o_result (t_result)
//
// create writes directly on an empty table, else reads the head, writes the new entry
// and relinks the head; start and set read the entry and write it; yield reads the
// current entry, walks up to 63 others, demotes the old one on a switch; find compares
// up to 64 entries, one memory read per cycle; o_done is registered from the last step
// synchronous active-low reset; table contents are undefined until created
// the result strobe cannot be stalled; busy holds off new commands
`default_nettype none

module round_robin_task_ring_scheduler_core
    import rrts_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   start,
    input  wire t_cmd   i_cmd,
    output logic        busy,
    output logic        o_done,
    output t_result     o_result
);

    t_mem_req             mem_req;
    logic [ENTRY_W-1:0]   rd_data;

    rrts_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_cmd     (i_cmd),
        .i_rd_data (rd_data),
        .o_mem_req (mem_req),
        .busy      (busy),
        .o_done    (o_done),
        .o_result  (o_result)
    );

    rrts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_addr (mem_req.rd_addr),
        .i_wr_en   (mem_req.wr_en),
        .i_wr_addr (mem_req.wr_addr),
        .i_wr_data (mem_req.wr_data),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire
